@@ src/secr_pkg.sv @@
package secr_pkg;

  // divert modes
  localparam logic [1:0] DivertNormal = 2'd1;
  localparam logic [1:0] DivertEco    = 2'd2;

  typedef enum logic [1:0] {
    KIND_MODE  = 2'd0,
    KIND_STATE = 2'd1,
    KIND_RATE  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_WAKE   = 2'd1,
    CMD_NOTICE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_SUPPLY_LEVEL = 3'd0,
    CFG_GRID_FEED    = 3'd1,
    CFG_SOLAR_FEED   = 3'd2,
    CFG_MIN_CURRENT  = 3'd3,
    CFG_DISC_CODE    = 3'd4,
    CFG_SLEEP_CODE   = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SUM,
    S_DIV,
    S_FINISH,
    S_EMIT
  } state_e;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 8;

  localparam int VoltsLow  = 110;
  localparam int VoltsHigh = 240;
  localparam int Reserve   = 100;
  localparam int Milli     = 1000;

  // signed numerator of the grid rate and its non-negative magnitude
  localparam int NumW      = 28;
  localparam int DivW      = 27;
  localparam int DenW      = 18;
  // reciprocal of each divisor scaled by 2^RcpShift
  localparam int RcpW      = 21;
  localparam int RcpShift  = DivW;
  // estimate, product, correction
  localparam int DivSteps  = 3;
  localparam int CntW      = $clog2(DivSteps);
  localparam int RateW     = 12;

  typedef struct packed {
    logic capture;
    logic decode;
    logic sum;
    logic div_step;
    logic finish;
    logic pop;
  } secr_cmd_t;

  typedef struct packed {
    logic is_rate;
    logic div_done;
    logic pending;
  } secr_sts_t;

endpackage

@@ src/secr_in_if.sv @@
interface secr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [1:0]  requested_divert;
  logic [7:0]  evse_state;
  logic [15:0] solar_power;
  logic signed [16:0] grid_power;
  logic [6:0]  present_pilot;
  logic [16:0] ev_milliamps;

  modport source (
    output valid, mode, requested_divert, evse_state, solar_power, grid_power,
           present_pilot, ev_milliamps,
    input  ready
  );
  modport sink (
    input  valid, mode, requested_divert, evse_state, solar_power, grid_power,
           present_pilot, ev_milliamps,
    output ready
  );
endinterface

@@ src/secr_out_if.sv @@
interface secr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [6:0] current_amps;
  logic [1:0] divert_mode;
  logic       last;

  modport source (
    output valid, command, current_amps, divert_mode, last,
    input  ready
  );
  modport sink (
    input  valid, command, current_amps, divert_mode, last,
    output ready
  );
endinterface

@@ src/secr_ctrl.sv @@
module secr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  secr_pkg::secr_sts_t sts_i,
  output secr_pkg::secr_cmd_t cmd_o
);

  secr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= secr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      secr_pkg::S_IDLE: begin
        if (in_valid_i) state_d = secr_pkg::S_DECODE;
      end
      secr_pkg::S_DECODE: begin
        state_d = sts_i.is_rate ? secr_pkg::S_SUM : secr_pkg::S_EMIT;
      end
      secr_pkg::S_SUM: begin
        state_d = secr_pkg::S_DIV;
      end
      secr_pkg::S_DIV: begin
        if (sts_i.div_done) state_d = secr_pkg::S_FINISH;
      end
      secr_pkg::S_FINISH: begin
        state_d = secr_pkg::S_EMIT;
      end
      secr_pkg::S_EMIT: begin
        if (!sts_i.pending) state_d = secr_pkg::S_IDLE;
      end
      default: state_d = secr_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      secr_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      secr_pkg::S_DECODE: cmd_o.decode   = 1'b1;
      secr_pkg::S_SUM:    cmd_o.sum      = 1'b1;
      secr_pkg::S_DIV:    cmd_o.div_step = 1'b1;
      secr_pkg::S_FINISH: cmd_o.finish   = 1'b1;
      secr_pkg::S_EMIT: begin
        out_valid_o = sts_i.pending;
        cmd_o.pop   = sts_i.pending && out_ready_i;
      end
      default: ;
    endcase
  end

endmodule

@@ src/secr_dp.sv @@
module secr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  secr_pkg::secr_cmd_t           cmd_i,
  output secr_pkg::secr_sts_t           sts_o,
  input  logic                          cfg_we_i,
  input  logic [secr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [secr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [1:0]                    mode_i,
  input  logic [1:0]                    requested_divert_i,
  input  logic [7:0]                    evse_state_i,
  input  logic [15:0]                   solar_power_i,
  input  logic signed [16:0]            grid_power_i,
  input  logic [6:0]                    present_pilot_i,
  input  logic [16:0]                   ev_milliamps_i,
  output logic [1:0]                    command_o,
  output logic [6:0]                    current_amps_o,
  output logic [1:0]                    divert_mode_o,
  output logic                          last_o
);

  localparam int NumW     = secr_pkg::NumW;
  localparam int DivW     = secr_pkg::DivW;
  localparam int DenW     = secr_pkg::DenW;
  localparam int CntW     = secr_pkg::CntW;
  localparam int RateW    = secr_pkg::RateW;
  localparam int RcpW     = secr_pkg::RcpW;
  localparam int RcpShift = secr_pkg::RcpShift;
  localparam int ProdW    = RateW + DenW;
  localparam int MavW     = 25;
  localparam int RcpOne   = 2 ** RcpShift;

  localparam logic [DenW-1:0] DenLow  = DenW'(secr_pkg::VoltsLow * secr_pkg::Milli);
  localparam logic [DenW-1:0] DenHigh = DenW'(secr_pkg::VoltsHigh * secr_pkg::Milli);
  localparam logic [CntW-1:0] CntLast = CntW'(secr_pkg::DivSteps - 1);

  localparam logic [RcpW-1:0] RcpGridLow   = RcpW'(RcpOne / int'(DenLow));
  localparam logic [RcpW-1:0] RcpGridHigh  = RcpW'(RcpOne / int'(DenHigh));
  localparam logic [RcpW-1:0] RcpSolarLow  = RcpW'(RcpOne / secr_pkg::VoltsLow);
  localparam logic [RcpW-1:0] RcpSolarHigh = RcpW'(RcpOne / secr_pkg::VoltsHigh);

  // configuration
  logic [1:0] supply_q;
  logic       grid_feed_q, solar_feed_q;
  logic [6:0] min_cur_q;
  logic [7:0] disc_code_q, sleep_code_q;

  // block state
  logic [1:0]              divert_q, divert_d;
  logic [7:0]              prev_evse_q, prev_evse_d;
  logic [6:0]              max_cur_q, max_cur_d;
  logic signed [RateW-1:0] rate_q, rate_d;

  // captured item
  secr_pkg::kind_e    kind_q;
  logic [1:0]         req_q;
  logic [7:0]         evse_q;
  logic [15:0]        solar_q;
  logic signed [16:0] grid_q;
  logic [6:0]         pilot_q;
  logic [16:0]        ma_q;

  // arithmetic
  logic [MavW-1:0]        mav_q;
  logic signed [NumW-1:0] gk_q;
  logic [DivW-1:0]        dvd_q;
  logic [DenW-1:0]        den_q;
  logic [RcpW-1:0]        rcp_q;
  logic [RateW-1:0]       quo_q;
  logic [ProdW-1:0]       prod_q;
  logic [CntW-1:0]        cnt_q;
  logic                   src_grid_q, src_solar_q, g_zero_q, g_neg_q;

  // results
  secr_pkg::cmd_e res_cmd_q [2];
  secr_pkg::cmd_e res_cmd_d [2];
  logic [6:0]     res_amps_q [2];
  logic [6:0]     res_amps_d [2];
  logic [1:0]     res_n_q, res_n_d;
  logic           res_idx_q, res_idx_d;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q     <= 2'd2;
      grid_feed_q  <= 1'b0;
      solar_feed_q <= 1'b0;
      min_cur_q    <= 7'd6;
      disc_code_q  <= 8'd1;
      sleep_code_q <= 8'd254;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        secr_pkg::CFG_SUPPLY_LEVEL: supply_q     <= cfg_wdata_i[1:0];
        secr_pkg::CFG_GRID_FEED:    grid_feed_q  <= cfg_wdata_i[0];
        secr_pkg::CFG_SOLAR_FEED:   solar_feed_q <= cfg_wdata_i[0];
        secr_pkg::CFG_MIN_CURRENT:  min_cur_q    <= cfg_wdata_i[6:0];
        secr_pkg::CFG_DISC_CODE:    disc_code_q  <= cfg_wdata_i;
        secr_pkg::CFG_SLEEP_CODE:   sleep_code_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= secr_pkg::kind_e'(mode_i);
      req_q   <= requested_divert_i;
      evse_q  <= evse_state_i;
      solar_q <= solar_power_i;
      grid_q  <= grid_power_i;
      pilot_q <= present_pilot_i;
      ma_q    <= ev_milliamps_i;
    end
  end

  // products of the grid numerator, one constant multiply each
  logic signed [17:0]     ng;
  logic signed [NumW-1:0] ng_w;
  logic signed [NumW-1:0] gk_d;
  logic [MavW-1:0]        mav_d;
  logic                   low_supply;

  assign low_supply = (supply_q == 2'd1);
  assign ng    = -{grid_q[16], grid_q} - 18'sd100;
  assign ng_w  = {{(NumW - 18){ng[17]}}, ng};
  assign gk_d  = ng_w * NumW'(secr_pkg::Milli);
  assign mav_d = low_supply ? MavW'(ma_q * MavW'(secr_pkg::VoltsLow))
                            : MavW'(ma_q * MavW'(secr_pkg::VoltsHigh));

  // numerator and divider load
  logic signed [NumW-1:0] num;
  assign num = gk_q + $signed({{(NumW - MavW){1'b0}}, mav_q});

  // reciprocal estimate is the quotient or one below it
  logic [DivW+RcpW-1:0] est_full;
  logic [RateW-1:0]     est;
  logic [ProdW-1:0]     dvd_w, rem_w;
  logic                 est_low;
  assign est_full = {{RcpW{1'b0}}, dvd_q} * {{DivW{1'b0}}, rcp_q};
  assign est      = est_full[RcpShift +: RateW];
  assign dvd_w    = {{(ProdW - DivW){1'b0}}, dvd_q};
  assign rem_w    = dvd_w - prod_q;
  assign est_low  = (rem_w >= {{(ProdW - DenW){1'b0}}, den_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      mav_q <= mav_d;
      gk_q  <= gk_d;
    end
    if (cmd_i.sum) begin
      src_grid_q  <= grid_feed_q;
      src_solar_q <= solar_feed_q;
      g_zero_q    <= (num <= -NumW'(100 * secr_pkg::Milli));
      g_neg_q     <= num[NumW-1];
      dvd_q       <= grid_feed_q ? num[DivW-1:0] : {{(DivW - 16){1'b0}}, solar_q};
      den_q       <= grid_feed_q ? (low_supply ? DenLow : DenHigh)
                                 : (low_supply ? DenW'(secr_pkg::VoltsLow)
                                               : DenW'(secr_pkg::VoltsHigh));
      rcp_q       <= grid_feed_q ? (low_supply ? RcpGridLow : RcpGridHigh)
                                 : (low_supply ? RcpSolarLow : RcpSolarHigh);
      cnt_q       <= '0;
    end else if (cmd_i.div_step) begin
      if (cnt_q == '0) begin
        quo_q <= est;
      end else if (cnt_q == CntW'(1)) begin
        prod_q <= {{DenW{1'b0}}, quo_q} * {{RateW{1'b0}}, den_q};
      end else if (est_low) begin
        quo_q <= quo_q + 1'b1;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // final clamp of the rate
  logic signed [RateW-1:0] r_sel;
  logic signed [RateW:0]   r13, r2, r3, minc13, maxc13, pilot13;
  logic                    sleeping;

  assign sleeping = (evse_q == sleep_code_q);
  assign minc13   = $signed({{(RateW - 6){1'b0}}, min_cur_q});
  assign maxc13   = $signed({{(RateW - 6){1'b0}}, max_cur_q});
  assign pilot13  = $signed({{(RateW - 6){1'b0}}, pilot_q});

  always_comb begin
    if (src_grid_q) begin
      if (g_zero_q)     r_sel = '0;
      else if (g_neg_q) r_sel = -RateW'(1);
      else              r_sel = $signed(quo_q);
    end else if (src_solar_q) begin
      r_sel = $signed(quo_q);
    end else begin
      r_sel = rate_q;
    end
    r13 = {r_sel[RateW-1], r_sel};
    r2  = (!sleeping && (r13 < minc13)) ? minc13 : r13;
    r3  = (r2 > maxc13) ? maxc13 : r2;
  end

  always_comb begin
    divert_d    = divert_q;
    prev_evse_d = prev_evse_q;
    max_cur_d   = max_cur_q;
    rate_d      = rate_q;
    res_cmd_d   = res_cmd_q;
    res_amps_d  = res_amps_q;
    res_n_d     = res_n_q;
    res_idx_d   = res_idx_q;

    if (cmd_i.decode) begin
      res_n_d   = 2'd0;
      res_idx_d = 1'b0;
      unique case (kind_q)
        secr_pkg::KIND_MODE: begin
          if ((req_q == secr_pkg::DivertNormal || req_q == secr_pkg::DivertEco) &&
              req_q != divert_q) begin
            divert_d = req_q;
            if (req_q == secr_pkg::DivertNormal) begin
              res_cmd_d[0]  = secr_pkg::CMD_SET;
              res_amps_d[0] = max_cur_q;
              res_cmd_d[1]  = secr_pkg::CMD_NOTICE;
              res_amps_d[1] = '0;
              res_n_d       = 2'd2;
            end else begin
              rate_d        = '0;
              max_cur_d     = pilot_q;
              res_cmd_d[0]  = secr_pkg::CMD_NOTICE;
              res_amps_d[0] = '0;
              res_n_d       = 2'd1;
            end
          end
        end
        secr_pkg::KIND_STATE: begin
          if (evse_q != prev_evse_q) begin
            prev_evse_d = evse_q;
            // car gone while in eco falls back to normal
            if (evse_q == disc_code_q && divert_q == secr_pkg::DivertEco) begin
              divert_d      = secr_pkg::DivertNormal;
              res_cmd_d[0]  = secr_pkg::CMD_SET;
              res_amps_d[0] = max_cur_q;
              res_cmd_d[1]  = secr_pkg::CMD_NOTICE;
              res_amps_d[1] = '0;
              res_n_d       = 2'd2;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd_i.finish) begin
      res_n_d   = 2'd0;
      res_idx_d = 1'b0;
      if (r2 >= minc13) begin
        rate_d = r3[RateW-1:0];
        if (pilot13 != r3) begin
          res_cmd_d[0]  = secr_pkg::CMD_SET;
          res_amps_d[0] = r3[6:0];
          res_cmd_d[1]  = secr_pkg::CMD_WAKE;
          res_amps_d[1] = '0;
          res_n_d       = sleeping ? 2'd2 : 2'd1;
        end else if (sleeping) begin
          res_cmd_d[0]  = secr_pkg::CMD_WAKE;
          res_amps_d[0] = '0;
          res_n_d       = 2'd1;
        end
      end else begin
        rate_d = r2[RateW-1:0];
      end
    end else if (cmd_i.pop) begin
      res_idx_d = 1'b1;
      if (res_idx_q) res_n_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divert_q    <= secr_pkg::DivertNormal;
      prev_evse_q <= 8'd255;
      max_cur_q   <= 7'd32;
      rate_q      <= '0;
      res_n_q     <= 2'd0;
      res_idx_q   <= 1'b0;
    end else begin
      divert_q    <= divert_d;
      prev_evse_q <= prev_evse_d;
      max_cur_q   <= max_cur_d;
      rate_q      <= rate_d;
      res_n_q     <= res_n_d;
      res_idx_q   <= res_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_cmd_q  <= res_cmd_d;
    res_amps_q <= res_amps_d;
  end

  assign sts_o.is_rate  = (kind_q == secr_pkg::KIND_RATE) &&
                          (divert_q == secr_pkg::DivertEco);
  assign sts_o.div_done = (cnt_q == CntLast);
  assign sts_o.pending  = ({1'b0, res_idx_q} < res_n_q);

  assign command_o      = res_cmd_q[res_idx_q];
  assign current_amps_o = res_amps_q[res_idx_q];
  assign divert_mode_o  = divert_q;
  assign last_o         = res_idx_q || (res_n_q == 2'd1);

endmodule

@@ src/solar_excess_charge_regulator_core.sv @@
// Solar excess charge regulator.
// in_i carries one item per handshake: a divert mode request, a charger
// state observation or a rate update. out_o returns zero, one or two
// charger commands per item, the final one flagged by last. The cfg_we_i
// port writes a setting register by index. The block handles one item at
// a time; in_i.ready is high only while idle. Mode requests and state
// observations pass through a decode state before their results. A rate
// update in eco mode passes through decode, sum, divide and finish states;
// the divide is a reciprocal multiply followed by a product and a one-step
// correction. A new item is accepted only after every result of the
// previous one has been taken. Items that give no result free the block
// without offering anything on out_o. A stalled receiver simply holds the
// current result on out_o and the block waits; no result is dropped. Reset
// puts the block in normal mode with max current 32 A, rate 0, the previous
// charger state invalid and the settings at 240 V, no feeds, 6 A minimum.
module solar_excess_charge_regulator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  secr_in_if.sink                       in_i,
  secr_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [secr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [secr_pkg::CfgDataW-1:0] cfg_wdata_i
);

  secr_pkg::secr_cmd_t cmd;
  secr_pkg::secr_sts_t sts;

  secr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  secr_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .mode_i             (in_i.mode),
    .requested_divert_i (in_i.requested_divert),
    .evse_state_i       (in_i.evse_state),
    .solar_power_i      (in_i.solar_power),
    .grid_power_i       (in_i.grid_power),
    .present_pilot_i    (in_i.present_pilot),
    .ev_milliamps_i     (in_i.ev_milliamps),
    .command_o          (out_o.command),
    .current_amps_o     (out_o.current_amps),
    .divert_mode_o      (out_o.divert_mode),
    .last_o             (out_o.last)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("result offered while taking a new item");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("item accepted twice in a row");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> !out_o.valid)
    else $error("result after the last one of an item");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.divert_mode == secr_pkg::DivertNormal ||
                     out_o.divert_mode == secr_pkg::DivertEco))
    else $error("divert mode out of range");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import secr_pkg::*;

  localparam int CycleLimit = 400_000;
  localparam int DrainWait  = 40;
  localparam int HoldCycles = 400;
  localparam int RandPhases = 8;
  localparam int PhaseItems = 150;

  typedef struct {
    kind_e              kind;
    logic [1:0]         want;
    logic [7:0]         evse;
    logic [15:0]        solar;
    logic signed [16:0] grid;
    logic [6:0]         pilot;
    logic [16:0]        ma;
  } charge_item_t;

  typedef struct {
    cmd_e       command;
    logic [6:0] amps;
    logic [1:0] mode;
    logic       last;
  } charger_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  secr_in_if  charge_in ();
  secr_out_if charge_out ();

  solar_excess_charge_regulator_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (charge_in),
    .out_o      (charge_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // settings mirror
  logic [1:0] cfg_supply;
  logic       cfg_grid;
  logic       cfg_solar;
  logic [6:0] cfg_min;
  logic [7:0] cfg_disc;
  logic [7:0] cfg_sleep;

  // regulator state mirror
  logic [1:0]              divert_now;
  logic [7:0]              prev_evse;
  logic [6:0]              max_amps;
  logic signed [RateW-1:0] rate_q;

  charge_item_t pending_items[$];
  charger_cmd_t charge_cmds[$];
  charge_item_t offered;
  charger_cmd_t step_cmds[2];
  int step_n;

  int  errors = 0;
  int  items_accepted = 0;
  int  cmds_checked = 0;
  int  cmd_seen[3] = '{0, 0, 0};
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;
  bit  hold_arm = 1'b0;
  bit  hold_used = 1'b0;
  int  hold_left = 0;
  logic [6:0] last_eco_pilot = 7'd32;

  function automatic void emit_cmd(cmd_e c, logic [6:0] a);
    step_cmds[step_n].command = c;
    step_cmds[step_n].amps    = a;
    step_cmds[step_n].mode    = divert_now;
    step_cmds[step_n].last    = 1'b0;
    step_n++;
  endfunction

  function automatic void switch_divert(logic [1:0] want, logic [6:0] pilot);
    if ((want != DivertNormal && want != DivertEco) || want == divert_now) return;
    divert_now = want;
    if (want == DivertNormal) begin
      emit_cmd(CMD_SET, max_amps);
    end else begin
      rate_q   = '0;
      max_amps = pilot;
    end
    emit_cmd(CMD_NOTICE, 7'd0);
  endfunction

  task automatic predict_item(input charge_item_t it);
    longint volts, r, minc, g, num, den, q;
    logic sleeping;
    step_n = 0;
    case (it.kind)
      KIND_MODE: switch_divert(it.want, it.pilot);
      KIND_STATE: begin
        if (it.evse != prev_evse) begin
          if (it.evse == cfg_disc && divert_now == DivertEco)
            switch_divert(DivertNormal, it.pilot);
          prev_evse = it.evse;
        end
      end
      KIND_RATE: begin
        if (divert_now == DivertEco) begin
          volts    = (cfg_supply == 2'd1) ? VoltsLow : VoltsHigh;
          r        = rate_q;
          minc     = cfg_min;
          g        = it.grid;
          sleeping = (it.evse == cfg_sleep);
          if (cfg_grid) begin
            if (g * Milli < longint'(it.ma) * volts) begin
              num = (-g - Reserve) * Milli + longint'(it.ma) * volts;
              den = Milli * volts;
              q   = num / den;
              // floor toward minus infinity
              if (num % den != 0 && num < 0) q--;
              r = q;
            end else begin
              r = 0;
            end
          end else if (cfg_solar) begin
            r = longint'(it.solar) / volts;
          end
          if (!sleeping && r < minc) r = minc;
          if (r >= minc) begin
            if (r > longint'(max_amps)) r = max_amps;
            if (longint'(it.pilot) != r) emit_cmd(CMD_SET, r[6:0]);
            if (sleeping) emit_cmd(CMD_WAKE, 7'd0);
          end
          rate_q = r[RateW-1:0];
        end
      end
      default: ;
    endcase
    if (step_n > 0) step_cmds[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) charge_cmds.push_back(step_cmds[i]);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      charge_in.valid <= 1'b0;
    end else begin
      if (charge_in.valid && charge_in.ready) begin
        predict_item(offered);
        items_accepted++;
      end
      if (!charge_in.valid || charge_in.ready) begin
        if (pending_items.size() > 0 && !(gaps_on && $urandom_range(99) < 21)) begin
          offered = pending_items.pop_front();
          charge_in.valid            <= 1'b1;
          charge_in.mode             <= offered.kind;
          charge_in.requested_divert <= offered.want;
          charge_in.evse_state       <= offered.evse;
          charge_in.solar_power      <= offered.solar;
          charge_in.grid_power       <= offered.grid;
          charge_in.present_pilot    <= offered.pilot;
          charge_in.ev_milliamps     <= offered.ma;
        end else begin
          charge_in.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      charge_out.ready <= 1'b0;
    end else begin
      if (charge_out.valid && charge_out.ready) begin
        if (charge_cmds.size() == 0) begin
          $error("command %0d with nothing outstanding", charge_out.command);
          errors++;
        end else begin
          charger_cmd_t want_cmd;
          want_cmd = charge_cmds.pop_front();
          cmds_checked++;
          if (charge_out.command < 3) cmd_seen[charge_out.command]++;
          if (charge_out.command !== want_cmd.command) begin
            $error("command: expected %0d, got %0d", want_cmd.command, charge_out.command);
            errors++;
          end
          if (charge_out.current_amps !== want_cmd.amps) begin
            $error("current_amps: expected %0d, got %0d", want_cmd.amps,
                   charge_out.current_amps);
            errors++;
          end
          if (charge_out.divert_mode !== want_cmd.mode) begin
            $error("divert_mode: expected %0d, got %0d", want_cmd.mode,
                   charge_out.divert_mode);
            errors++;
          end
          if (charge_out.last !== want_cmd.last) begin
            $error("last: expected %0d, got %0d", want_cmd.last, charge_out.last);
            errors++;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_arm && !hold_used) begin
        hold_used        <= 1'b1;
        hold_left        <= HoldCycles;
        charge_out.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left        <= hold_left - 1;
        charge_out.ready <= 1'b0;
      end else begin
        charge_out.ready <= !(gaps_on && $urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("solar_excess_charge_regulator_core verification failed");
      $finish;
    end
  end

  function automatic charge_item_t make_item(kind_e k, logic [1:0] want, logic [7:0] evse,
                                             logic [15:0] solar, int grid,
                                             logic [6:0] pilot, logic [16:0] ma);
    charge_item_t it;
    it.kind  = k;
    it.want  = want;
    it.evse  = evse;
    it.solar = solar;
    it.grid  = grid[16:0];
    it.pilot = pilot;
    it.ma    = ma;
    return it;
  endfunction

  function automatic charge_item_t random_item();
    charge_item_t it;
    int pick;
    it = make_item(KIND_RATE, 2'($urandom_range(3)), 8'($urandom_range(255)),
                   16'($urandom), int'($urandom_range(131071)) - 65536,
                   7'($urandom_range(80)), 17'($urandom_range(80000)));
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.kind = KIND_MODE;
      if ($urandom_range(9) == 0) it.want = $urandom_range(1) ? 2'd3 : 2'd0;
      else it.want = ($urandom_range(3) != 0) ? DivertEco : DivertNormal;
      if (it.want == DivertEco) last_eco_pilot = it.pilot;
    end else if (pick < 20) begin
      it.kind = KIND_STATE;
      if ($urandom_range(3) == 0) it.evse = cfg_disc;
      else if ($urandom_range(2) == 0) it.evse = cfg_sleep;
    end else if (pick < 95) begin
      if ($urandom_range(3) == 0) it.evse = cfg_sleep;
      pick = $urandom_range(9);
      if (pick < 3) it.pilot = last_eco_pilot;
      else if (pick < 5) it.pilot = cfg_min;
      // keep half the grid readings near the interesting export band
      if ($urandom_range(1)) it.grid = 17'(int'($urandom_range(26000)) - 25000);
    end else begin
      it.kind = KIND_NONE;
    end
    return it;
  endfunction

  task automatic write_setting(cfg_idx_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(logic [1:0] supply, logic grid, logic solar,
                                logic [6:0] minc, logic [7:0] disc, logic [7:0] sleep);
    write_setting(CFG_SUPPLY_LEVEL, 8'(supply));
    write_setting(CFG_GRID_FEED, 8'(grid));
    write_setting(CFG_SOLAR_FEED, 8'(solar));
    write_setting(CFG_MIN_CURRENT, 8'(minc));
    write_setting(CFG_DISC_CODE, disc);
    write_setting(CFG_SLEEP_CODE, sleep);
    cfg_supply = supply;
    cfg_grid   = grid;
    cfg_solar  = solar;
    cfg_min    = minc;
    cfg_disc   = disc;
    cfg_sleep  = sleep;
    @(negedge clk_i);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || charge_in.valid || charge_cmds.size() != 0);
    // items with no result may still be in flight
    repeat (DrainWait) @(negedge clk_i);
  endtask

  initial begin
    charge_in.valid            = 1'b0;
    charge_in.mode             = '0;
    charge_in.requested_divert = '0;
    charge_in.evse_state       = '0;
    charge_in.solar_power      = '0;
    charge_in.grid_power       = '0;
    charge_in.present_pilot    = '0;
    charge_in.ev_milliamps     = '0;
    charge_out.ready           = 1'b0;
    cfg_we_i                   = 1'b0;
    cfg_idx_i                  = '0;
    cfg_wdata_i                = '0;

    cfg_supply = 2'd2;
    cfg_grid   = 1'b0;
    cfg_solar  = 1'b0;
    cfg_min    = 7'd6;
    cfg_disc   = 8'd1;
    cfg_sleep  = 8'd254;
    divert_now = DivertNormal;
    prev_evse  = 8'd255;
    max_amps   = 7'd32;
    rate_q     = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: no feeds, so the rate carries over
    pending_items.push_back(make_item(KIND_RATE, DivertEco, 8'd3, 16'd500, -500, 7'd0, 17'd0));
    pending_items.push_back(make_item(KIND_NONE, DivertEco, 8'd3, 16'd0, 0, 7'd0, 17'd0));
    pending_items.push_back(make_item(KIND_MODE, DivertNormal, 8'd3, 16'd0, 0, 7'd5, 17'd0));
    pending_items.push_back(make_item(KIND_MODE, 2'd0, 8'd3, 16'd0, 0, 7'd5, 17'd0));
    pending_items.push_back(make_item(KIND_MODE, 2'd3, 8'd3, 16'd0, 0, 7'd5, 17'd0));
    pending_items.push_back(make_item(KIND_MODE, DivertEco, 8'd3, 16'd0, 0, 7'd80, 17'd0));
    pending_items.push_back(make_item(KIND_MODE, DivertEco, 8'd3, 16'd0, 0, 7'd10, 17'd0));
    pending_items.push_back(make_item(KIND_RATE, 2'd0, 8'd3, 16'd0, 0, 7'd0, 17'd0));
    pending_items.push_back(make_item(KIND_RATE, 2'd0, 8'd254, 16'd0, 0, 7'd6, 17'd0));
    pending_items.push_back(make_item(KIND_STATE, 2'd0, 8'd255, 16'd0, 0, 7'd0, 17'd0));
    pending_items.push_back(make_item(KIND_STATE, 2'd0, 8'd1, 16'd0, 0, 7'd0, 17'd0));
    pending_items.push_back(make_item(KIND_STATE, 2'd0, 8'd1, 16'd0, 0, 7'd0, 17'd0));
    drain();

    // 110 V grid feed: extremes, zero rate and the negative floor while asleep
    apply_settings(2'd1, 1'b1, 1'b1, 7'd0, 8'd0, 8'd0);
    pending_items.push_back(make_item(KIND_STATE, 2'd0, 8'd7, 16'd0, 0, 7'd0, 17'd0));
    pending_items.push_back(make_item(KIND_MODE, DivertEco, 8'd7, 16'd0, 0, 7'd80, 17'd0));
    pending_items.push_back(make_item(KIND_RATE, 2'd0, 8'd5, 16'hFFFF, -65536, 7'd0,
                                      17'd80000));
    pending_items.push_back(make_item(KIND_RATE, 2'd0, 8'd5, 16'd0, 65535, 7'd7, 17'd80000));
    pending_items.push_back(make_item(KIND_RATE, 2'd0, 8'd5, 16'd0, -150, 7'd0, 17'd0));
    pending_items.push_back(make_item(KIND_RATE, 2'd0, 8'd0, 16'd0, -99, 7'd3, 17'd0));
    drain();

    // 240 V solar only, 80 A minimum, shared sleep and disconnect code
    apply_settings(2'd2, 1'b0, 1'b1, 7'd80, 8'd255, 8'd255);
    pending_items.push_back(make_item(KIND_RATE, 2'd0, 8'd9, 16'hFFFF, 0, 7'd0, 17'd0));
    pending_items.push_back(make_item(KIND_RATE, 2'd0, 8'd255, 16'd0, 0, 7'd80, 17'd0));
    pending_items.push_back(make_item(KIND_RATE, 2'd0, 8'd9, 16'd0, 0, 7'd80, 17'd0));
    pending_items.push_back(make_item(KIND_STATE, 2'd0, 8'd255, 16'd0, 0, 7'd0, 17'd0));
    pending_items.push_back(make_item(KIND_MODE, DivertEco, 8'd9, 16'd0, 0, 7'd0, 17'd0));
    pending_items.push_back(make_item(KIND_MODE, DivertNormal, 8'd9, 16'd0, 0, 7'd0, 17'd0));
    drain();

    for (int p = 0; p < RandPhases; p++) begin
      logic [1:0] supply;
      logic [6:0] minc;
      logic [7:0] disc, sleep;
      supply = (p == 0) ? 2'd1 : (p == 1) ? 2'd2 : 2'($urandom_range(1, 2));
      minc   = (p == 0) ? 7'd0 : (p == 1) ? 7'd80 : 7'($urandom_range(20));
      disc   = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : 8'($urandom_range(255));
      sleep  = (p == 0) ? 8'd255 : (p == 1) ? 8'd0 : 8'($urandom_range(255));
      apply_settings(supply, p % 4 < 2, p % 4 == 0 || p % 4 == 2, minc, disc, sleep);
      gaps_on = (p != 5);
      for (int i = 0; i < PhaseItems; i++) pending_items.push_back(random_item());
      if (p == 2) hold_arm = 1'b1;
      drain();
    end

    $display("%0d items in, %0d commands checked (set %0d, wake %0d, notice %0d)",
             items_accepted, cmds_checked, cmd_seen[0], cmd_seen[1], cmd_seen[2]);
    $display("covered %0d random setting phases, grid/solar/no-feed, both supply levels",
             RandPhases);
    if (errors == 0) begin
      $display("solar_excess_charge_regulator_core verification clean");
    end else begin
      $display("solar_excess_charge_regulator_core verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/secr_pkg.sv
src/secr_in_if.sv
src/secr_out_if.sv
src/secr_ctrl.sv
src/secr_dp.sv
src/solar_excess_charge_regulator_core.sv
dv/testbench.sv
